// File: hdl/kalc_pkg.sv
package kalc_pkg;

	// PIN length in key codes
	localparam int PIN_DIGITS = 4;
	localparam int DC_W = $clog2(PIN_DIGITS + 1);
	localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
	localparam int PIN_W = 16;
	localparam int KEY_W = 4;
	localparam int TMO_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Controller modes
	localparam logic [3:0] M_LOCKED = 4'd0;
	localparam logic [3:0] M_SLEEP = 4'd1;
	localparam logic [3:0] M_AUTH = 4'd2;
	localparam logic [3:0] M_MENU = 4'd3;
	localparam logic [3:0] M_ARM = 4'd4;
	localparam logic [3:0] M_BUZZ_ON = 4'd5;
	localparam logic [3:0] M_BUZZ_OFF = 4'd6;
	localparam logic [3:0] M_NEW_PIN = 4'd7;
	localparam logic [3:0] M_SAVE = 4'd8;
	localparam logic [3:0] M_ABOUT = 4'd9;

	// Event opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_KEY = 2'd1;
	localparam logic [1:0] OP_UNLOCK = 2'd2;
	localparam logic [1:0] OP_INTRUDE = 2'd3;

	// Menu keys
	localparam logic [KEY_W-1:0] KEY_A = 4'd3;
	localparam logic [KEY_W-1:0] KEY_B = 4'd7;
	localparam logic [KEY_W-1:0] KEY_C = 4'd11;
	localparam logic [KEY_W-1:0] KEY_D = 4'd15;

	// Authentication outcome
	localparam logic [1:0] AUTH_NONE = 2'd0;
	localparam logic [1:0] AUTH_MATCH = 2'd1;
	localparam logic [1:0] AUTH_FAIL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TMO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_TMO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAVE_TMO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_PIN = 3'd3;

	// Reset values
	localparam logic [TMO_W-1:0] LONG_TMO_RST = 8'd120;
	localparam logic [TMO_W-1:0] BUZZ_TMO_RST = 8'd5;
	localparam logic [TMO_W-1:0] SAVE_TMO_RST = 8'd8;
	localparam logic [PIN_W-1:0] POWER_PIN_RST = 16'hDDDD;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key_code;
	} evt_t;

	typedef struct packed {
		logic [3:0]       mode;
		logic             buzzer_on;
		logic             sensor_armed;
		logic             unlock_enabled;
		logic [1:0]       auth_result;
		logic             save_strobe;
		logic [PIN_W-1:0] stored_pin_out;
	} res_t;

	typedef struct packed {
		logic [TMO_W-1:0] long_timeout;
		logic [TMO_W-1:0] buzzer_timeout;
		logic [TMO_W-1:0] save_timeout;
		logic [PIN_W-1:0] power_up_pin;
	} cfg_t;

	// Reset digit of the stored PIN; digits past the fourth are zero
	function automatic logic [KEY_W-1:0] pin_digit_rst(input int i);
		logic [PIN_W-1:0] sh;
		sh = POWER_PIN_RST >> (KEY_W * i);
		if (i < 4)
			return sh[KEY_W-1:0];
		else
			return '0;
	endfunction

endpackage

// File: hdl/kalc_evt_if.sv
interface kalc_evt_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [kalc_pkg::KEY_W-1:0] key_code;

	modport source (output valid, output opcode, output key_code, input ready);
	modport sink (input valid, input opcode, input key_code, output ready);
endinterface

// File: hdl/kalc_res_if.sv
interface kalc_res_if;
	logic                      valid;
	logic                      ready;
	logic [3:0]                mode;
	logic                      buzzer_on;
	logic                      sensor_armed;
	logic                      unlock_enabled;
	logic [1:0]                auth_result;
	logic                      save_strobe;
	logic [kalc_pkg::PIN_W-1:0] stored_pin_out;

	modport source (output valid, output mode, output buzzer_on, output sensor_armed,
		output unlock_enabled, output auth_result, output save_strobe,
		output stored_pin_out, input ready);
	modport sink (input valid, input mode, input buzzer_on, input sensor_armed,
		input unlock_enabled, input auth_result, input save_strobe,
		input stored_pin_out, output ready);
endinterface

// File: hdl/kalc_fsm.sv
module kalc_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  kalc_pkg::evt_t   evt,
	input  kalc_pkg::cfg_t   cfg,
	output kalc_pkg::res_t   res
);

	logic [3:0]                         mode_q, mode_d;
	logic [kalc_pkg::TMO_W-1:0]         cd_q, cd_d;
	logic [kalc_pkg::DC_W-1:0]          dc_q, dc_d;
	logic [kalc_pkg::KEY_W-1:0]         ent_q [kalc_pkg::PIN_DIGITS];
	logic [kalc_pkg::KEY_W-1:0]         ent_d [kalc_pkg::PIN_DIGITS];
	logic [kalc_pkg::KEY_W-1:0]         sto_q [kalc_pkg::PIN_DIGITS];
	logic [kalc_pkg::KEY_W-1:0]         sto_d [kalc_pkg::PIN_DIGITS];
	logic                               buz_q, buz_d;
	logic                               arm_q, arm_d;
	logic                               unl_q, unl_d;
	logic [1:0]                         auth;
	logic                               strobe;
	logic                               expired;
	logic                               last_digit;
	logic                               same;
	logic [kalc_pkg::IDX_W-1:0]         idx;
	logic [kalc_pkg::PIN_W-1:0]         pin_packed;
	logic [kalc_pkg::PIN_W-1:0]         pin_held;

	assign expired = (cd_q == '0);
	assign idx = dc_q[kalc_pkg::IDX_W-1:0];
	assign last_digit = (dc_q == kalc_pkg::DC_W'(kalc_pkg::PIN_DIGITS - 1));

	// Next state for one item
	always_comb begin
		mode_d = mode_q;
		cd_d = cd_q;
		dc_d = dc_q;
		ent_d = ent_q;
		sto_d = sto_q;
		buz_d = buz_q;
		arm_d = arm_q;
		unl_d = unl_q;
		auth = kalc_pkg::AUTH_NONE;
		strobe = 1'b0;
		same = 1'b1;

		if (mode_q == kalc_pkg::M_LOCKED)
			unl_d = 1'b1;
		if (mode_q == kalc_pkg::M_MENU)
			unl_d = 1'b0;

		unique case (evt.opcode)
			kalc_pkg::OP_UNLOCK: begin
				if (unl_d) begin
					mode_d = kalc_pkg::M_AUTH;
					cd_d = cfg.long_timeout;
					dc_d = '0;
				end
			end
			kalc_pkg::OP_INTRUDE: begin
				if (arm_q) begin
					mode_d = kalc_pkg::M_BUZZ_ON;
					cd_d = cfg.buzzer_timeout;
				end
			end
			kalc_pkg::OP_KEY: begin
				priority if (mode_q == kalc_pkg::M_AUTH) begin
					ent_d[idx] = evt.key_code;
					dc_d = dc_q + 1'b1;
					if (last_digit) begin
						for (int i = 0; i < kalc_pkg::PIN_DIGITS; i++)
							if (ent_d[i] != sto_q[i])
								same = 1'b0;
						dc_d = '0;
						if (same) begin
							auth = kalc_pkg::AUTH_MATCH;
							mode_d = kalc_pkg::M_MENU;
							cd_d = cfg.long_timeout;
							unl_d = 1'b0;
						end else begin
							auth = kalc_pkg::AUTH_FAIL;
						end
					end
				end else if (mode_q == kalc_pkg::M_MENU) begin
					priority if (evt.key_code == kalc_pkg::KEY_A) begin
						mode_d = kalc_pkg::M_ARM;
						cd_d = cfg.long_timeout;
					end else if (evt.key_code == kalc_pkg::KEY_B) begin
						mode_d = kalc_pkg::M_BUZZ_OFF;
						cd_d = cfg.buzzer_timeout;
					end else if (evt.key_code == kalc_pkg::KEY_C) begin
						mode_d = kalc_pkg::M_NEW_PIN;
						cd_d = cfg.long_timeout;
						dc_d = '0;
					end else if (evt.key_code == kalc_pkg::KEY_D) begin
						mode_d = kalc_pkg::M_ABOUT;
						cd_d = cfg.long_timeout;
					end
				end else if (mode_q == kalc_pkg::M_NEW_PIN) begin
					sto_d[idx] = evt.key_code;
					dc_d = dc_q + 1'b1;
					if (last_digit) begin
						dc_d = '0;
						mode_d = kalc_pkg::M_SAVE;
						cd_d = cfg.save_timeout;
					end
				end
			end
			kalc_pkg::OP_TICK: begin
				unique case (mode_q)
					kalc_pkg::M_LOCKED: begin
						if (expired) begin
							mode_d = kalc_pkg::M_SLEEP;
							cd_d = '0;
						end else begin
							cd_d = cd_q - 1'b1;
						end
					end
					kalc_pkg::M_AUTH, kalc_pkg::M_MENU, kalc_pkg::M_NEW_PIN,
					kalc_pkg::M_ARM, kalc_pkg::M_BUZZ_ON, kalc_pkg::M_BUZZ_OFF,
					kalc_pkg::M_SAVE, kalc_pkg::M_ABOUT: begin
						if (expired) begin
							if (mode_q == kalc_pkg::M_ARM) begin
								buz_d = 1'b0;
								arm_d = 1'b1;
							end
							if (mode_q == kalc_pkg::M_BUZZ_ON) begin
								buz_d = 1'b1;
								arm_d = 1'b0;
							end
							if (mode_q == kalc_pkg::M_BUZZ_OFF)
								buz_d = 1'b0;
							if (mode_q == kalc_pkg::M_SAVE)
								strobe = 1'b1;
							mode_d = kalc_pkg::M_LOCKED;
							cd_d = cfg.long_timeout;
							unl_d = 1'b1;
						end else begin
							cd_d = cd_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	// Pack the first four stored digits
	always_comb begin
		pin_packed = '0;
		for (int i = 0; i < kalc_pkg::PIN_DIGITS; i++)
			if (i < 4)
				pin_packed[kalc_pkg::KEY_W*(i%4) +: kalc_pkg::KEY_W] = sto_d[i];
	end

	// Pack the stored digits as they stand between items
	always_comb begin
		pin_held = '0;
		for (int i = 0; i < kalc_pkg::PIN_DIGITS; i++)
			if (i < 4)
				pin_held[kalc_pkg::KEY_W*(i%4) +: kalc_pkg::KEY_W] = sto_q[i];
	end

	assign res.mode = mode_d;
	assign res.buzzer_on = buz_d;
	assign res.sensor_armed = arm_d;
	assign res.unlock_enabled = unl_d;
	assign res.auth_result = auth;
	assign res.save_strobe = strobe;
	assign res.stored_pin_out = pin_packed;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kalc_pkg::M_LOCKED;
			cd_q <= kalc_pkg::LONG_TMO_RST;
			dc_q <= '0;
			buz_q <= 1'b0;
			arm_q <= 1'b0;
			unl_q <= 1'b0;
			for (int i = 0; i < kalc_pkg::PIN_DIGITS; i++)
				sto_q[i] <= kalc_pkg::pin_digit_rst(i);
		end else if (step) begin
			mode_q <= mode_d;
			cd_q <= cd_d;
			dc_q <= dc_d;
			buz_q <= buz_d;
			arm_q <= arm_d;
			unl_q <= unl_d;
			sto_q <= sto_d;
		end
	end

	// Entered digits: written before any read
	always_ff @(posedge clk) begin
		if (step)
			ent_q <= ent_d;
	end

	// Digit count never reaches the PIN length between items
	a_dc_range: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q < kalc_pkg::DC_W'(kalc_pkg::PIN_DIGITS))
		else $error("digit count overran");

	// Locked mode always leaves unlock enabled
	a_locked_unl: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.mode == kalc_pkg::M_LOCKED |-> res.unlock_enabled)
		else $error("locked without unlock enabled");

	// Save strobe only on expiry of save mode
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.save_strobe |-> mode_q == kalc_pkg::M_SAVE && expired
			&& evt.opcode == kalc_pkg::OP_TICK)
		else $error("save strobe outside save mode");

	// Auth outcome only from a key in PIN entry
	a_auth_src: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.auth_result != kalc_pkg::AUTH_NONE |->
			mode_q == kalc_pkg::M_AUTH && evt.opcode == kalc_pkg::OP_KEY && last_digit)
		else $error("auth outcome outside PIN entry");

	// Stored PIN changes only through new-PIN keys
	a_pin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && mode_q == kalc_pkg::M_NEW_PIN && evt.opcode == kalc_pkg::OP_KEY)
			|=> $stable(pin_held))
		else $error("stored PIN changed outside new-PIN entry");

endmodule

// File: hdl/keypad_alarm_lock_controller_top.sv
// Channel  Dir  Handshake      Payload
// evt      in   valid/ready    opcode[1:0], key_code[3:0]
// res      out  valid/ready    mode, buzzer_on, sensor_armed, unlock_enabled,
//                              auth_result, save_strobe, stored_pin_out
// cfg      in   cfg_we only    cfg_index[2:0], cfg_data[15:0]
//
// An item passes from acceptance through the input register, then through the
// mode logic into the result register. One item is accepted every cycle while
// the result is not stalled; the mode logic runs once per item.
// arst_n clears mode, counters and flags, loads the countdown and the timeouts
// with their defaults (long timeout 120) and loads the stored PIN with 0xDDDD.
// A stalled result holds the result register and the input register; evt.ready
// stays high while the input register is empty or moving forward.
module keypad_alarm_lock_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kalc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kalc_pkg::CFG_DATA_W-1:0]     cfg_data,
	kalc_evt_if.sink                            evt,
	kalc_res_if.source                          res
);

	kalc_pkg::cfg_t cfg_q;
	kalc_pkg::evt_t evt_s1;
	logic           vld_s1;
	kalc_pkg::res_t res_d;
	kalc_pkg::res_t res_q;
	logic           res_vld_q;
	logic           adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_timeout <= kalc_pkg::LONG_TMO_RST;
			cfg_q.buzzer_timeout <= kalc_pkg::BUZZ_TMO_RST;
			cfg_q.save_timeout <= kalc_pkg::SAVE_TMO_RST;
			cfg_q.power_up_pin <= kalc_pkg::POWER_PIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kalc_pkg::CFG_LONG_TMO: cfg_q.long_timeout <= cfg_data[kalc_pkg::TMO_W-1:0];
				kalc_pkg::CFG_BUZZ_TMO: cfg_q.buzzer_timeout <= cfg_data[kalc_pkg::TMO_W-1:0];
				kalc_pkg::CFG_SAVE_TMO: cfg_q.save_timeout <= cfg_data[kalc_pkg::TMO_W-1:0];
				kalc_pkg::CFG_POWER_PIN: cfg_q.power_up_pin <= cfg_data[kalc_pkg::PIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance when the result register is free or being drained
	assign adv = vld_s1 && (!res_vld_q || res.ready);
	assign evt.ready = !vld_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (evt.ready)
			vld_s1 <= evt.valid;
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1.opcode <= evt.opcode;
			evt_s1.key_code <= evt.key_code;
		end
	end

	kalc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.evt    (evt_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (adv)
			res_vld_q <= 1'b1;
		else if (res.ready)
			res_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

	assign res.valid = res_vld_q;
	assign res.mode = res_q.mode;
	assign res.buzzer_on = res_q.buzzer_on;
	assign res.sensor_armed = res_q.sensor_armed;
	assign res.unlock_enabled = res_q.unlock_enabled;
	assign res.auth_result = res_q.auth_result;
	assign res.save_strobe = res_q.save_strobe;
	assign res.stored_pin_out = res_q.stored_pin_out;

	// A result waiting downstream blocks the mode logic
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !res.ready |-> !adv)
		else $error("result overwritten while stalled");

	// Every item in the input register reaches the result register
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(evt_s1))
		else $error("input register lost an item");

	// A processed item always leaves a valid result
	a_res_after: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_vld_q)
		else $error("result missing after step");

endmodule
